// ----- rtl/strong_probable_prime_test_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the strong probable prime test core.
// Full concurrent assertions in simulation, empty bodies under synthesis.
// ----------------------------------------------------------------------------
`ifndef STRONG_PROBABLE_PRIME_TEST_CORE_MACROS_SVH
`define STRONG_PROBABLE_PRIME_TEST_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define SPRP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sprp assertion failed");

// Check that cons holds in the cycle after ante.
`define SPRP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sprp assertion failed");

`else

`define SPRP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SPRP_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/sprp_pkg.sv -----
// ----------------------------------------------------------------------------
// sprp_pkg
// Request and response types of the strong probable prime test core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sprp_pkg;

  localparam int unsigned FIELD_WIDTH = 32;

  // One test request: candidate n and witness base a
  typedef struct packed {
    logic [FIELD_WIDTH-1:0] candidate;
    logic [FIELD_WIDTH-1:0] witness_base;
  } sprp_req_t;

  // One test response
  typedef struct packed {
    logic probable_prime;
    logic bad_input;
  } sprp_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/strong_probable_prime_test_core.sv -----
// ----------------------------------------------------------------------------
// strong_probable_prime_test_core
// One Miller-Rabin round on a NUM_WIDTH-bit candidate against one base.
// ----------------------------------------------------------------------------
// Usage:
//   Present a request (candidate n, witness base a) on req with req_valid;
//   it is taken when req_ready is high. Only the low NUM_WIDTH bits of each
//   field count. One response per request comes out on rsp with rsp_valid.
//   bad_input flags n below two, with probable_prime low.
//   The core works on one request at a time. Each modular multiply runs
//   through a single shared multiplier and bit-serial reducer. A request
//   takes at most k + h + s + 1 multiplies, with k the bit length of d,
//   h the number of ones in d, s the power of two in n-1; n < 2 takes none.
//   The response sits in an output register: the next request is taken
//   while it waits. A stalled receiver holds rsp; a later request then
//   waits in its final state until the register frees.
//   Reset (rst, synchronous) returns the sequencer to idle and drops rsp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "strong_probable_prime_test_core_macros.svh"

module strong_probable_prime_test_core #(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire sprp_pkg::sprp_req_t  req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output sprp_pkg::sprp_rsp_t       rsp
);

  import sprp_pkg::*;

  localparam int unsigned SW = $clog2(NUM_WIDTH);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_SPLIT  = 10'b0000000010,
    ST_REDUCE = 10'b0000000100,
    ST_STEP   = 10'b0000001000,
    ST_MULX   = 10'b0000010000,
    ST_SQB    = 10'b0000100000,
    ST_CHECK  = 10'b0001000000,
    ST_LOOP   = 10'b0010000000,
    ST_SQX    = 10'b0100000000,
    ST_FINISH = 10'b1000000000
  } sprp_state_t;

  sprp_state_t          state;
  logic [NUM_WIDTH-1:0] n;
  logic [NUM_WIDTH-1:0] nm1;
  logic [NUM_WIDTH-1:0] a;
  logic [NUM_WIDTH-1:0] d;
  logic [NUM_WIDTH-1:0] e;
  logic [NUM_WIDTH-1:0] x;
  logic [NUM_WIDTH-1:0] b;
  logic [SW-1:0]        s;
  logic [SW-1:0]        cnt;
  logic                 pass;
  logic                 bad;

  logic                 mm_start;
  logic [NUM_WIDTH-1:0] mm_a;
  logic [NUM_WIDTH-1:0] mm_b;
  logic                 mm_done;
  logic [NUM_WIDTH-1:0] mm_result;
  logic                 mm_wait;

  logic [NUM_WIDTH-1:0] cand;

  assign cand      = req.candidate[NUM_WIDTH-1:0];
  assign req_ready = (state == ST_IDLE);

  // States that wait on the shared multiplier
  assign mm_wait = (state == ST_REDUCE) || (state == ST_MULX) ||
                   (state == ST_SQB) || (state == ST_SQX);

  // Launch the shared multiplier and pick its operands
  always_comb begin
    mm_start = 1'b0;
    mm_a     = x;
    mm_b     = b;
    unique case (state)
      ST_SPLIT: begin
        if (d[0]) begin
          mm_start = 1'b1;
          mm_a     = a;
          mm_b     = NUM_WIDTH'(1);
        end
      end
      ST_STEP: begin
        if (e != '0) begin
          mm_start = 1'b1;
          mm_a     = e[0] ? x : b;
        end
      end
      ST_MULX: begin
        if (mm_done) begin
          mm_start = 1'b1;
          mm_a     = b;
        end
      end
      ST_LOOP: begin
        if (cnt != '0 && x != nm1) begin
          mm_start = 1'b1;
          mm_b     = x;
        end
      end
      default: mm_start = 1'b0;
    endcase
  end

  sprp_modmul #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .op_a   (mm_a),
    .op_b   (mm_b),
    .modulus(n),
    .done   (mm_done),
    .result (mm_result)
  );

  // Sequence one test round and hold the response
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != ST_FINISH) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            n   <= cand;
            a   <= req.witness_base[NUM_WIDTH-1:0];
            nm1 <= cand - NUM_WIDTH'(1);
            d   <= cand - NUM_WIDTH'(1);
            s   <= '0;
            if (cand[NUM_WIDTH-1:1] == '0) begin
              pass  <= 1'b0;
              bad   <= 1'b1;
              state <= ST_FINISH;
            end else begin
              bad   <= 1'b0;
              state <= ST_SPLIT;
            end
          end
        end
        ST_SPLIT: begin
          // Strip factors of two from n-1
          if (!d[0]) begin
            d <= d >> 1;
            s <= s + SW'(1);
          end else begin
            state <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (mm_done) begin
            b     <= mm_result;
            x     <= NUM_WIDTH'(1);
            e     <= d;
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (e == '0) begin
            state <= ST_CHECK;
          end else if (e[0]) begin
            state <= ST_MULX;
          end else begin
            state <= ST_SQB;
          end
        end
        ST_MULX: begin
          if (mm_done) begin
            x     <= mm_result;
            state <= ST_SQB;
          end
        end
        ST_SQB: begin
          if (mm_done) begin
            b     <= mm_result;
            e     <= e >> 1;
            state <= ST_STEP;
          end
        end
        ST_CHECK: begin
          if (x == NUM_WIDTH'(1)) begin
            pass  <= 1'b1;
            state <= ST_FINISH;
          end else begin
            cnt   <= s;
            state <= ST_LOOP;
          end
        end
        ST_LOOP: begin
          // Look for n-1 over the remaining squarings
          if (cnt == '0) begin
            pass  <= 1'b0;
            state <= ST_FINISH;
          end else if (x == nm1) begin
            pass  <= 1'b1;
            state <= ST_FINISH;
          end else begin
            state <= ST_SQX;
          end
        end
        ST_SQX: begin
          if (mm_done) begin
            x     <= mm_result;
            cnt   <= cnt - SW'(1);
            state <= ST_LOOP;
          end
        end
        ST_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid          <= 1'b1;
            rsp.probable_prime <= pass;
            rsp.bad_input      <= bad;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SPRP_ASSERT_IMP(a_split_nonzero, clk, rst, state == ST_SPLIT, d != '0)
  `SPRP_ASSERT_IMP(a_done_expected, clk, rst, mm_done, mm_wait)
  `SPRP_ASSERT_IMP(a_bad_not_prime, clk, rst, rsp_valid && rsp.bad_input, !rsp.probable_prime)
  `SPRP_ASSERT_NXT(a_finish_loads, clk, rst, state == ST_FINISH && !rsp_valid, rsp_valid && state == ST_IDLE)

endmodule

`default_nettype wire

// ----- rtl/sprp_modmul.sv -----
// ----------------------------------------------------------------------------
// sprp_modmul
// Shared modular multiplier: a registered product, then a restoring
// reduction of the double-width product by the modulus, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "strong_probable_prime_test_core_macros.svh"

module sprp_modmul #(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [NUM_WIDTH-1:0] op_a,
  input  wire logic [NUM_WIDTH-1:0] op_b,
  input  wire logic [NUM_WIDTH-1:0] modulus,
  output logic                      done,
  output logic      [NUM_WIDTH-1:0] result
);

  localparam int unsigned PW = 2 * NUM_WIDTH;
  localparam int unsigned CW = $clog2(PW);

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_MUL  = 3'b010,
    M_RED  = 3'b100
  } mm_state_t;

  mm_state_t            state;
  logic [NUM_WIDTH-1:0] opa;
  logic [NUM_WIDTH-1:0] opb;
  logic [NUM_WIDTH-1:0] m;
  logic [PW-1:0]        prod;
  logic [CW-1:0]        cnt;
  logic [NUM_WIDTH:0]   trial;
  logic                 fits;
  logic [NUM_WIDTH:0]   diff;

  // Shift the next product bit into the partial remainder
  assign trial = {result, prod[PW-1]};
  assign fits  = trial >= {1'b0, m};
  assign diff  = trial - {1'b0, m};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      // Flag the result on the cycle after the last reduction step
      done <= (state == M_RED) && (cnt == CW'(PW - 1));
      unique case (state)
        M_IDLE: begin
          if (start) begin
            opa   <= op_a;
            opb   <= op_b;
            m     <= modulus;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          prod   <= PW'(opa) * PW'(opb);
          result <= '0;
          cnt    <= '0;
          state  <= M_RED;
        end
        M_RED: begin
          // Subtract the modulus whenever the shifted remainder reaches it
          result <= fits ? diff[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
          prod   <= {prod[PW-2:0], 1'b0};
          cnt    <= cnt + CW'(1);
          if (cnt == CW'(PW - 1)) begin
            state <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  `SPRP_ASSERT_IMP(a_start_idle, clk, rst, start, state == M_IDLE)
  `SPRP_ASSERT_IMP(a_result_below_mod, clk, rst, done, result < m)
  `SPRP_ASSERT_NXT(a_mul_then_red, clk, rst, state == M_MUL, state == M_RED)

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: strong probable prime test core
// Drives single-round Miller-Rabin requests through the valid/ready request
// channel with bursty timing, stalls the response channel on its own
// pattern, and compares every response against a cycle-free predictor
// built on 64-bit modular arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import sprp_pkg::*;

  localparam int unsigned NUM_WIDTH    = 32;
  localparam int unsigned LIMIT_CYCLES = 10_000_000;
  localparam int unsigned TAIL_CYCLES  = 300;
  localparam int unsigned RANDOM_ITEMS = 150;

  // Receiver stall patterns
  typedef enum int unsigned {
    RDY_OPEN,
    RDY_COIN,
    RDY_SPARSE,
    RDY_HOLD
  } ready_mode_t;

  // Kinds of random request
  typedef enum int unsigned {
    PICK_ODD_WIDE,
    PICK_KNOWN,
    PICK_SMALL,
    PICK_ANY,
    PICK_BELOW_TWO,
    PICK_MULTIPLE,
    PICK_NEAR_N
  } pick_kind_t;

  // One awaited response with the request that caused it
  typedef struct {
    sprp_req_t req;
    sprp_rsp_t rsp;
  } sprp_expect_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  sprp_req_t req       = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  sprp_rsp_t rsp;

  sprp_expect_t sprp_pending_q[$];

  int unsigned fail_count    = 0;
  int unsigned checked_count = 0;
  int unsigned prime_count   = 0;
  int unsigned bad_count     = 0;
  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;

  ready_mode_t ready_mode = RDY_OPEN;
  int unsigned ready_hold = 0;

  strong_probable_prime_test_core #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One Miller-Rabin round: n-1 = d*2^s, x = a^d mod n, then s squarings
  function automatic sprp_rsp_t predict_sprp(input logic [FIELD_WIDTH-1:0] cand,
                                             input logic [FIELD_WIDTH-1:0] base);
    bit [63:0]   mask;
    bit [63:0]   n;
    bit [63:0]   d;
    bit [63:0]   e;
    bit [63:0]   x;
    bit [63:0]   b;
    int unsigned s;
    bit          found;
    sprp_rsp_t   res;
    mask = (64'd1 << NUM_WIDTH) - 64'd1;
    n    = 64'(cand) & mask;
    res  = '0;
    if (n < 64'd2) begin
      res.bad_input = 1'b1;
      return res;
    end
    d = n - 64'd1;
    s = 0;
    while (d[0] == 1'b0 && s < 64) begin
      d = d >> 1;
      s++;
    end
    e = d;
    x = 64'd1;
    b = (64'(base) & mask) % n;
    while (e != 64'd0) begin
      if (e[0]) x = (x * b) % n;
      b = (b * b) % n;
      e = e >> 1;
    end
    found = (x == 64'd1);
    for (int unsigned r = 0; r < s; r++) begin
      if (!found) begin
        if (x == n - 64'd1) found = 1'b1;
        else x = (x * x) % n;
      end
    end
    res.probable_prime = found;
    return res;
  endfunction

  // Primes and strong pseudoprimes for the random mix
  function automatic logic [31:0] known_candidate(input int unsigned idx);
    case (idx)
      0:       return 32'd3;
      1:       return 32'd5;
      2:       return 32'd65537;
      3:       return 32'd2147483647;
      4:       return 32'd4294967291;
      5:       return 32'd4294967279;
      6:       return 32'd1000000007;
      7:       return 32'd998244353;
      8:       return 32'd3221225473;
      9:       return 32'd2047;
      10:      return 32'd1373653;
      11:      return 32'd25326001;
      default: return 32'd3215031751;
    endcase
  endfunction

  // Send one request in bursts with random gaps; log the expected response
  task automatic send_request(input logic [31:0] cand, input logic [31:0] base);
    int unsigned  gap;
    sprp_req_t    item;
    sprp_expect_t entry;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 7) == 0) gap = $urandom_range(1, 4000);
      else gap = $urandom_range(0, 3);
      if (gap > 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    item.candidate    = cand;
    item.witness_base = base;
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    entry.req = item;
    entry.rsp = predict_sprp(cand, base);
    sprp_pending_q.push_back(entry);
  endtask

  // Candidates below two: flagged, never prime
  task automatic test_bad_input();
    send_request(32'd0, 32'd0);
    send_request(32'd0, 32'hFFFF_FFFF);
    send_request(32'd1, 32'd0);
    send_request(32'd1, 32'hFFFF_FFFF);
  endtask

  // Even candidates: s is zero, only x == 1 passes
  task automatic test_even_candidates();
    send_request(32'd2, 32'd1);
    send_request(32'd2, 32'd2);
    send_request(32'd2, 32'hFFFF_FFFF);
    send_request(32'd4, 32'd3);
    send_request(32'd4, 32'd1);
    send_request(32'hFFFF_FFFE, 32'h1234_5677);
  endtask

  // Bases that are multiples of n reduce to zero
  task automatic test_base_multiples();
    send_request(32'd7, 32'd0);
    send_request(32'd7, 32'd7);
    send_request(32'd7, 32'd14);
    send_request(32'hFFFF_FFFB, 32'hFFFF_FFFB);
  endtask

  // Field extremes, large s, base n-1, a pseudoprime and a Carmichael number
  task automatic test_extremes();
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_request(32'hFFFF_FFFB, 32'd1);
    send_request(32'h8000_0001, 32'd2);
    send_request(32'hC000_0001, 32'd5);
    send_request(32'd2047, 32'd2);
    send_request(32'd561, 32'd2);
    send_request(32'd3, 32'd2);
  endtask

  // Mostly odd candidates with random bases, plus edge-case noise
  task automatic test_random_mix();
    pick_kind_t  kind;
    logic [31:0] cand;
    logic [31:0] base;
    int unsigned roll;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 38)      kind = PICK_ODD_WIDE;
      else if (roll < 58) kind = PICK_KNOWN;
      else if (roll < 73) kind = PICK_SMALL;
      else if (roll < 83) kind = PICK_ANY;
      else if (roll < 88) kind = PICK_BELOW_TWO;
      else if (roll < 94) kind = PICK_MULTIPLE;
      else                kind = PICK_NEAR_N;
      base = $urandom;
      case (kind)
        PICK_ODD_WIDE: cand = $urandom | 32'd1;
        PICK_KNOWN:    cand = known_candidate($urandom_range(0, 12));
        PICK_SMALL:    cand = $urandom_range(2, 65535);
        PICK_ANY:      cand = $urandom;
        PICK_BELOW_TWO: cand = $urandom_range(0, 1);
        PICK_MULTIPLE: begin
          cand = $urandom_range(2, 65535);
          base = cand * $urandom_range(0, 65535);
        end
        default: begin
          cand = $urandom | 32'd1;
          base = cand + $urandom_range(0, 2) - 32'd1;
        end
      endcase
      send_request(cand, base);
    end
  endtask

  // Stall the response side on a pattern of changing modes
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_hold = (ready_mode == RDY_HOLD) ? $urandom_range(1, 2000)
                                            : $urandom_range(1, 300);
    end
    ready_hold--;
    case (ready_mode)
      RDY_OPEN:   rsp_ready <= 1'b1;
      RDY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
      default:    rsp_ready <= 1'b0;
    endcase
  end

  // Compare each accepted response with the oldest expectation
  always @(posedge clk) begin
    sprp_expect_t head;
    if (!rst && rsp_valid && rsp_ready) begin
      if (sprp_pending_q.size() == 0) begin
        $error("response with no request pending: probable_prime=%0b bad_input=%0b",
               rsp.probable_prime, rsp.bad_input);
        fail_count++;
      end else begin
        head = sprp_pending_q.pop_front();
        checked_count++;
        if (head.rsp.probable_prime) prime_count++;
        if (head.rsp.bad_input) bad_count++;
        if (rsp.probable_prime !== head.rsp.probable_prime) begin
          $error("probable_prime n=%0d a=%0d: expected %0b, actual %0b",
                 head.req.candidate, head.req.witness_base,
                 head.rsp.probable_prime, rsp.probable_prime);
          fail_count++;
        end
        if (rsp.bad_input !== head.rsp.bad_input) begin
          $error("bad_input n=%0d a=%0d: expected %0b, actual %0b",
                 head.req.candidate, head.req.witness_base,
                 head.rsp.bad_input, rsp.bad_input);
          fail_count++;
        end
      end
    end
  end

  // Drop the run if it overruns the cycle budget
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, sprp_pending_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_bad_input();
    test_even_candidates();
    test_base_multiples();
    test_extremes();
    test_random_mix();

    @(negedge clk);
    req_valid <= 1'b0;

    // Drain outstanding responses, then watch for strays
    while (sprp_pending_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d responses: %0d probable primes, %0d bad inputs, %0d cycles",
             checked_count, prime_count, bad_count, cycle_count);
    $display("covered n below two, even n, zero bases, large s and strong pseudoprimes");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
